### rtl/tcpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpt_pkg: shared definitions for the tetrahedron critical point test
// Holds the default coordinate width, the sign codes and the table that maps
// each vertex minor onto the vertex vector taking part in its dot product.
// ----------------------------------------------------------------------------
package tcpt_pkg;

    localparam int DEFAULT_COORD_WIDTH = 16;

    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    // Minor i omits vertex i. Minors a and b use the cross product c x d,
    // minors c and d use a x b; this table names the dotted vertex.
    localparam int DOT_VERTEX [4] = '{1, 0, 3, 2};

    function automatic logic [1:0] sign_code(input logic neg, input logic zero);
        logic [1:0] code;
        if (zero)
        begin
            code = SIGN_ZERO;
        end
        else if (neg)
        begin
            code = SIGN_NEG;
        end
        else
        begin
            code = SIGN_POS;
        end
        return code;
    endfunction

    function automatic logic [1:0] sign_negate(input logic [1:0] code);
        logic [1:0] res;
        unique case (code)
            SIGN_POS:  res = SIGN_NEG;
            SIGN_NEG:  res = SIGN_POS;
            default:   res = SIGN_ZERO;
        endcase
        return res;
    endfunction

endpackage

### rtl/tet_critical_point_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_critical_point_test: exact critical point test for one tetrahedron
// Pipeline: eight register stages; a result is offered once its input
// transaction has passed through them all, held longer only while the output is stalled.
// Throughput: one transaction per cycle, set by the fully pipelined
// multiplier and adder stages; a stalled output holds the whole pipeline.
// Reset: rst_n clears every valid bit asynchronously; data registers keep
// whatever they hold.
// ----------------------------------------------------------------------------
module tet_critical_point_test
    import tcpt_pkg::*;
#(
    parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] vel_a_x,
    input  logic signed [COORD_WIDTH-1:0] vel_a_y,
    input  logic signed [COORD_WIDTH-1:0] vel_a_z,
    input  logic signed [COORD_WIDTH-1:0] vel_b_x,
    input  logic signed [COORD_WIDTH-1:0] vel_b_y,
    input  logic signed [COORD_WIDTH-1:0] vel_b_z,
    input  logic signed [COORD_WIDTH-1:0] vel_c_x,
    input  logic signed [COORD_WIDTH-1:0] vel_c_y,
    input  logic signed [COORD_WIDTH-1:0] vel_c_z,
    input  logic signed [COORD_WIDTH-1:0] vel_d_x,
    input  logic signed [COORD_WIDTH-1:0] vel_d_y,
    input  logic signed [COORD_WIDTH-1:0] vel_d_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          has_fixed_point,
    output logic signed [1:0]             base_orientation
);

    logic                           advance;
    logic signed [COORD_WIDTH-1:0]  vec_in [4][3];
    logic                           cross_valid;
    logic signed [COORD_WIDTH-1:0]  cross_vec [4][3];
    logic signed [2*COORD_WIDTH:0]  cross_ab [3];
    logic signed [2*COORD_WIDTH:0]  cross_cd [3];
    logic                           dot_valid;
    logic signed [3*COORD_WIDTH:0]  minor [4];

    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    assign vec_in[0] = '{vel_a_x, vel_a_y, vel_a_z};
    assign vec_in[1] = '{vel_b_x, vel_b_y, vel_b_z};
    assign vec_in[2] = '{vel_c_x, vel_c_y, vel_c_z};
    assign vec_in[3] = '{vel_d_x, vel_d_y, vel_d_z};

    tcpt_cross #(
        .W (COORD_WIDTH)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (in_valid),
        .vec_in    (vec_in),
        .valid_out (cross_valid),
        .vec_out   (cross_vec),
        .cross_ab  (cross_ab),
        .cross_cd  (cross_cd)
    );

    tcpt_dot #(
        .W (COORD_WIDTH)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (cross_valid),
        .vec_in    (cross_vec),
        .cross_ab  (cross_ab),
        .cross_cd  (cross_cd),
        .valid_out (dot_valid),
        .minor     (minor)
    );

    tcpt_sign #(
        .W (COORD_WIDTH)
    ) u_sign (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .valid_in         (dot_valid),
        .minor            (minor),
        .out_valid        (out_valid),
        .has_fixed_point  (has_fixed_point),
        .base_orientation (base_orientation)
    );

endmodule

### rtl/tcpt_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpt_cross: input register and cross product stages
// Registers the four vertex vectors, forms the twelve coordinate products and
// then the cross products a x b and c x d, carrying the vectors alongside.
// ----------------------------------------------------------------------------
module tcpt_cross
    import tcpt_pkg::*;
#(
    parameter int W = DEFAULT_COORD_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 valid_in,
    input  logic signed [W-1:0]  vec_in [4][3],
    output logic                 valid_out,
    output logic signed [W-1:0]  vec_out [4][3],
    output logic signed [2*W:0]  cross_ab [3],
    output logic signed [2*W:0]  cross_cd [3]
);

    logic                  valid1_reg;
    logic                  valid2_reg;
    logic                  valid3_reg;
    logic signed [W-1:0]   vec1_reg [4][3];
    logic signed [W-1:0]   vec2_reg [4][3];
    logic signed [W-1:0]   vec3_reg [4][3];
    logic signed [2*W-1:0] pos_next [2][3];
    logic signed [2*W-1:0] neg_next [2][3];
    logic signed [2*W-1:0] pos_reg [2][3];
    logic signed [2*W-1:0] neg_reg [2][3];
    logic signed [2*W:0]   cross_next [2][3];
    logic signed [2*W:0]   cross_reg [2][3];

    always_comb
    begin
        for (int p = 0; p < 2; p++)
        begin
            pos_next[p][0] = vec1_reg[2*p][1] * vec1_reg[2*p+1][2];
            neg_next[p][0] = vec1_reg[2*p][2] * vec1_reg[2*p+1][1];
            pos_next[p][1] = vec1_reg[2*p][2] * vec1_reg[2*p+1][0];
            neg_next[p][1] = vec1_reg[2*p][0] * vec1_reg[2*p+1][2];
            pos_next[p][2] = vec1_reg[2*p][0] * vec1_reg[2*p+1][1];
            neg_next[p][2] = vec1_reg[2*p][1] * vec1_reg[2*p+1][0];
        end
    end

    always_comb
    begin
        for (int p = 0; p < 2; p++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cross_next[p][k] = (2*W+1)'(pos_reg[p][k]) - (2*W+1)'(neg_reg[p][k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid1_reg <= valid_in;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vec1_reg  <= vec_in;
            vec2_reg  <= vec1_reg;
            vec3_reg  <= vec2_reg;
            pos_reg   <= pos_next;
            neg_reg   <= neg_next;
            cross_reg <= cross_next;
        end
    end

    assign valid_out = valid3_reg;
    assign vec_out   = vec3_reg;
    assign cross_ab  = cross_reg[0];
    assign cross_cd  = cross_reg[1];

endmodule

### rtl/tcpt_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpt_dot: triple product stages
// Forms the four 3x3 vertex minors as dot products of a vertex with a cross
// product. Each cross component is split into a high and a low half so that
// no multiplier grows much beyond the coordinate width.
// ----------------------------------------------------------------------------
module tcpt_dot
    import tcpt_pkg::*;
#(
    parameter int W = DEFAULT_COORD_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 valid_in,
    input  logic signed [W-1:0]  vec_in [4][3],
    input  logic signed [2*W:0]  cross_ab [3],
    input  logic signed [2*W:0]  cross_cd [3],
    output logic                 valid_out,
    output logic signed [3*W:0]  minor [4]
);

    localparam int TW = 3 * W;
    localparam int DW = 3 * W + 1;

    logic                  valid4_reg;
    logic                  valid5_reg;
    logic                  valid6_reg;
    logic signed [2*W:0]   cr [4][3];
    logic signed [W:0]     hi_op [4][3];
    logic signed [W:0]     lo_op [4][3];
    logic signed [2*W:0]   hi_next [4][3];
    logic signed [2*W:0]   lo_next [4][3];
    logic signed [2*W:0]   hi_reg [4][3];
    logic signed [2*W:0]   lo_reg [4][3];
    logic signed [TW-1:0]  term_next [4][3];
    logic signed [TW-1:0]  term_reg [4][3];
    logic signed [DW-1:0]  minor_next [4];
    logic signed [DW-1:0]  minor_reg [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cr[i][k]      = (i < 2) ? cross_cd[k] : cross_ab[k];
                hi_op[i][k]   = $signed(cr[i][k][2*W:W]);
                lo_op[i][k]   = $signed({1'b0, cr[i][k][W-1:0]});
                hi_next[i][k] = hi_op[i][k] * vec_in[DOT_VERTEX[i]][k];
                lo_next[i][k] = lo_op[i][k] * vec_in[DOT_VERTEX[i]][k];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                term_next[i][k] = TW'($signed({hi_reg[i][k], {W{1'b0}}}))
                                + TW'(lo_reg[i][k]);
            end
            minor_next[i] = DW'(term_reg[i][0]) + DW'(term_reg[i][1])
                          + DW'(term_reg[i][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
            valid6_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid4_reg <= valid_in;
            valid5_reg <= valid4_reg;
            valid6_reg <= valid5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            term_reg  <= term_next;
            minor_reg <= minor_next;
        end
    end

    assign valid_out = valid6_reg;
    assign minor     = minor_reg;

endmodule

### rtl/tcpt_sign.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpt_sign: determinant sum, sign compare and output register
// The full orientation determinant is the alternating sum of the four minors,
// and each determinant with one vertex set to zero is a single signed minor.
// The five signs are compared and the result is held in the output register.
// ----------------------------------------------------------------------------
module tcpt_sign
    import tcpt_pkg::*;
#(
    parameter int W = DEFAULT_COORD_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 valid_in,
    input  logic signed [3*W:0]  minor [4],
    output logic                 out_valid,
    output logic                 has_fixed_point,
    output logic signed [1:0]    base_orientation
);

    localparam int PW = 3 * W + 2;
    localparam int SW = 3 * W + 3;

    logic                 valid7_reg;
    logic                 out_valid_reg;
    logic signed [PW-1:0] pair_next [2];
    logic signed [PW-1:0] pair_reg [2];
    logic [1:0]           vsign_next [4];
    logic [1:0]           vsign_reg [4];
    logic signed [SW-1:0] total;
    logic [1:0]           base_code;
    logic                 agree;
    logic                 fixed_next;
    logic                 fixed_reg;
    logic signed [1:0]    base_reg;

    always_comb
    begin
        pair_next[0] = PW'(minor[1]) - PW'(minor[0]);
        pair_next[1] = PW'(minor[3]) - PW'(minor[2]);
        for (int i = 0; i < 4; i++)
        begin
            if ((i % 2) == 0)
            begin
                vsign_next[i] = sign_negate(sign_code(minor[i][3*W], minor[i] == '0));
            end
            else
            begin
                vsign_next[i] = sign_code(minor[i][3*W], minor[i] == '0);
            end
        end
    end

    always_comb
    begin
        total     = SW'(pair_reg[0]) + SW'(pair_reg[1]);
        base_code = sign_code(total[SW-1], total == '0);
        agree     = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            if (vsign_reg[i] != base_code)
            begin
                agree = 1'b0;
            end
        end
        fixed_next = agree;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid7_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid7_reg    <= valid_in;
            out_valid_reg <= valid7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pair_reg  <= pair_next;
            vsign_reg <= vsign_next;
            fixed_reg <= fixed_next;
            base_reg  <= $signed(base_code);
        end
    end

    assign out_valid        = out_valid_reg;
    assign has_fixed_point  = fixed_reg;
    assign base_orientation = base_reg;

endmodule

### rtl/tcpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpt_checker: port level checks for the critical point test
// Watches the handshakes and the result code on the top level ports.
// ----------------------------------------------------------------------------
module tcpt_checker
    import tcpt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              has_fixed_point,
    input logic signed [1:0] base_orientation
);

    // A result that is held back stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(has_fixed_point)
                                   && $stable(base_orientation))
        else $error("stalled result changed or vanished");

    // The input side is held back exactly when a finished result is not taken.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the output register");

    a_base_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (base_orientation == SIGN_POS || base_orientation == SIGN_ZERO
                       || base_orientation == SIGN_NEG))
        else $error("orientation code out of range");

    // Advancing with no transaction offered drains every stage of the pipeline.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && !in_stall) [*8] |=> !out_valid)
        else $error("unexpected result");

endmodule

bind tet_critical_point_test tcpt_checker u_tcpt_checker (.*);
